// File: design/gcsd_pkg.sv
// ----------------------------------------------------------------------------
// gcsd_pkg: channel to synthesizer divider definitions
// Band and status codes, field widths, frequency bases and the constants
// of the divide-by-130 reciprocal used by the divider block.
// ----------------------------------------------------------------------------
package gcsd_pkg;

  localparam int unsigned ChWidth    = 12;
  localparam int unsigned FreqWidth  = 15;
  localparam int unsigned BandWidth  = 3;
  localparam int unsigned SelWidth   = 2;
  localparam int unsigned IntWidth   = 7;
  localparam int unsigned FracWidth  = 8;
  localparam int unsigned StatWidth  = 2;

  localparam logic [BandWidth-1:0] BandC850  = 3'd0;
  localparam logic [BandWidth-1:0] BandC900  = 3'd1;
  localparam logic [BandWidth-1:0] BandC1800 = 3'd2;
  localparam logic [BandWidth-1:0] BandC1900 = 3'd3;
  localparam logic [BandWidth-1:0] BandC450  = 3'd4;
  localparam logic [BandWidth-1:0] BandC480  = 3'd5;
  localparam logic [BandWidth-1:0] BandC810  = 3'd6;
  localparam logic [BandWidth-1:0] BandC750  = 3'd7;

  localparam logic [StatWidth-1:0] StatOk          = 2'd0;
  localparam logic [StatWidth-1:0] StatNoBand      = 2'd1;
  localparam logic [StatWidth-1:0] StatUnsupported = 2'd2;

  // uplink base frequencies, 100 kHz units
  localparam logic [FreqWidth-1:0] Base1900   = 15'd18502;
  localparam logic [FreqWidth-1:0] Base900Lo  = 15'd8900;
  localparam logic [FreqWidth-1:0] Base900Hi  = 15'd6852;
  localparam logic [FreqWidth-1:0] Base850    = 15'd8242;
  localparam logic [FreqWidth-1:0] Base1800   = 15'd17102;
  localparam logic [FreqWidth-1:0] Base450    = 15'd4506;
  localparam logic [FreqWidth-1:0] Base480    = 15'd4790;
  localparam logic [FreqWidth-1:0] Base810    = 15'd8060;
  localparam logic [FreqWidth-1:0] Base750    = 15'd7472;

  // VCO / 4 fits 14 bits; floor(q / 130) = (q * RecipMul) >> RecipShift
  localparam int unsigned QWidth     = 14;
  localparam int unsigned RecipShift = 21;
  localparam int unsigned RecipWidth = 15;
  localparam logic [RecipWidth-1:0] RecipMul = 15'd16132;
  localparam logic [QWidth-1:0]     FracDiv  = 14'd130;

  typedef struct packed {
    logic                 in_band;
    logic [BandWidth-1:0] band;
    logic [FreqWidth-1:0] freq;
    logic                 uplink;
  } band_info_t;

endpackage

// File: design/gsm_channel_to_synth_divider_unit.sv
// ----------------------------------------------------------------------------
// gsm_channel_to_synth_divider_unit: GSM channel to synthesizer divider
// Classifies a channel request into its band and computes carrier frequency,
// band select, transmit-path flag and PLL integer and fraction values.
// ----------------------------------------------------------------------------
// A transaction is taken on every cycle that start is high; busy stays low,
// so a new channel may be issued every clock. Its result passes the input
// register and the result register around one pass of classification and
// divider logic, and appears for a single cycle, marked by done_o.
// The receiver cannot stall, so each result must be captured when done_o is
// high.
module gsm_channel_to_synth_divider_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [gcsd_pkg::ChWidth-1:0]        channel_number_i,
  input  logic                                pcs_flag_i,
  input  logic                                uplink_i,
  output logic                                done_o,
  output logic [gcsd_pkg::FreqWidth-1:0]      freq_tenths_mhz_o,
  output logic [gcsd_pkg::BandWidth-1:0]      band_code_o,
  output logic [gcsd_pkg::SelWidth-1:0]       band_select_o,
  output logic                                tx_path_o,
  output logic [gcsd_pkg::IntWidth-1:0]       pll_integer_o,
  output logic [gcsd_pkg::FracWidth-1:0]      pll_fraction_o,
  output logic                                out_of_spec_o,
  output logic [gcsd_pkg::StatWidth-1:0]      status_o
);
  import gcsd_pkg::*;

  logic                 in_v_q;
  logic [ChWidth-1:0]   ch_q;
  logic                 pcs_q;
  logic                 up_q;
  band_info_t           info;

  logic                 res_v_q;
  logic [FreqWidth-1:0] freq_d, freq_q;
  logic [BandWidth-1:0] band_d, band_q;
  logic [SelWidth-1:0]  sel_d, sel_q;
  logic                 tx_d, tx_q;
  logic [IntWidth-1:0]  nint_d, nint_q;
  logic [FracWidth-1:0] nfrac_d, nfrac_q;
  logic                 oos_d, oos_q;
  logic [StatWidth-1:0] stat_d, stat_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      in_v_q  <= start && !busy;
      res_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      ch_q  <= channel_number_i;
      pcs_q <= pcs_flag_i;
      up_q  <= uplink_i;
    end
  end

  gcsd_classify u_classify (
    .channel_number_i (ch_q),
    .pcs_flag_i       (pcs_q),
    .uplink_i         (up_q),
    .info_o           (info)
  );

  gcsd_divider u_divider (
    .info_i            (info),
    .freq_tenths_mhz_o (freq_d),
    .band_code_o       (band_d),
    .band_select_o     (sel_d),
    .tx_path_o         (tx_d),
    .pll_integer_o     (nint_d),
    .pll_fraction_o    (nfrac_d),
    .out_of_spec_o     (oos_d),
    .status_o          (stat_d)
  );

  always_ff @(posedge clk_i) begin
    if (in_v_q) begin
      freq_q  <= freq_d;
      band_q  <= band_d;
      sel_q   <= sel_d;
      tx_q    <= tx_d;
      nint_q  <= nint_d;
      nfrac_q <= nfrac_d;
      oos_q   <= oos_d;
      stat_q  <= stat_d;
    end
  end

  assign done_o            = res_v_q;
  assign freq_tenths_mhz_o = freq_q;
  assign band_code_o       = band_q;
  assign band_select_o     = sel_q;
  assign tx_path_o         = tx_q;
  assign pll_integer_o     = nint_q;
  assign pll_fraction_o    = nfrac_q;
  assign out_of_spec_o     = oos_q;
  assign status_o          = stat_q;

`ifndef ASSERT_OFF
  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 done_o)
    else $error("accepted transaction produced no result");

  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> ##1 !done_o)
    else $error("result without accepted transaction");

  a_ok_synth_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == StatOk) |-> (band_code_o[BandWidth-1] == 1'b0))
    else $error("ok status on a band the synthesizer lacks");

  a_noband_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == StatNoBand) |-> (freq_tenths_mhz_o == '0 && !tx_path_o))
    else $error("invalid channel with nonzero outputs");
`endif

endmodule

// File: design/gcsd_classify.sv
// ----------------------------------------------------------------------------
// gcsd_classify: band classification and carrier frequency
// Maps a channel number to its band and computes the uplink or downlink
// carrier frequency in 100 kHz units.
// ----------------------------------------------------------------------------
module gcsd_classify (
  input  logic [gcsd_pkg::ChWidth-1:0] channel_number_i,
  input  logic                         pcs_flag_i,
  input  logic                         uplink_i,
  output gcsd_pkg::band_info_t         info_o
);
  import gcsd_pkg::*;

  logic [ChWidth-1:0]   start;
  logic [FreqWidth-1:0] base;
  logic [FreqWidth-1:0] dup;
  logic [ChWidth-1:0]   offs;
  logic [FreqWidth-1:0] ul;
  logic                 hit;
  logic [BandWidth-1:0] band;

  always_comb begin
    hit   = 1'b1;
    band  = BandC900;
    start = '0;
    base  = Base900Lo;
    dup   = 15'd450;
    if (pcs_flag_i) begin
      hit   = (channel_number_i >= 12'd512) && (channel_number_i <= 12'd810);
      band  = BandC1900;
      start = 12'd512;
      base  = Base1900;
      dup   = 15'd800;
    end else if (channel_number_i <= 12'd124) begin
      band  = BandC900;
    end else if (channel_number_i >= 12'd955 && channel_number_i <= 12'd1023) begin
      band  = BandC900;
      base  = Base900Hi;
    end else if (channel_number_i >= 12'd128 && channel_number_i <= 12'd251) begin
      band  = BandC850;
      start = 12'd128;
      base  = Base850;
    end else if (channel_number_i >= 12'd512 && channel_number_i <= 12'd885) begin
      band  = BandC1800;
      start = 12'd512;
      base  = Base1800;
      dup   = 15'd950;
    end else if (channel_number_i >= 12'd259 && channel_number_i <= 12'd293) begin
      band  = BandC450;
      start = 12'd259;
      base  = Base450;
      dup   = 15'd100;
    end else if (channel_number_i >= 12'd306 && channel_number_i <= 12'd340) begin
      band  = BandC480;
      start = 12'd306;
      base  = Base480;
      dup   = 15'd100;
    end else if (channel_number_i >= 12'd350 && channel_number_i <= 12'd425) begin
      band  = BandC810;
      start = 12'd350;
      base  = Base810;
    end else if (channel_number_i >= 12'd438 && channel_number_i <= 12'd511) begin
      band  = BandC750;
      start = 12'd438;
      base  = Base750;
      dup   = 15'd300;
    end else begin
      hit   = 1'b0;
    end
  end

  assign offs = channel_number_i - start;
  assign ul   = base + {2'b00, offs, 1'b0};

  assign info_o.in_band = hit;
  assign info_o.band    = band;
  assign info_o.freq    = uplink_i ? ul : ul + dup;
  assign info_o.uplink  = uplink_i;

endmodule

// File: design/gcsd_divider.sv
// ----------------------------------------------------------------------------
// gcsd_divider: synthesizer divider calculation
// Chooses band select and VCO multiplier, then splits the VCO frequency into
// PLL integer (VCO / 520) and fraction parts with a reciprocal multiply.
// ----------------------------------------------------------------------------
module gcsd_divider (
  input  gcsd_pkg::band_info_t                info_i,
  output logic [gcsd_pkg::FreqWidth-1:0]      freq_tenths_mhz_o,
  output logic [gcsd_pkg::BandWidth-1:0]      band_code_o,
  output logic [gcsd_pkg::SelWidth-1:0]       band_select_o,
  output logic                                tx_path_o,
  output logic [gcsd_pkg::IntWidth-1:0]       pll_integer_o,
  output logic [gcsd_pkg::FracWidth-1:0]      pll_fraction_o,
  output logic                                out_of_spec_o,
  output logic [gcsd_pkg::StatWidth-1:0]      status_o
);
  import gcsd_pkg::*;

  localparam int unsigned ProdWidth = QWidth + RecipWidth;

  logic                  low_band;
  logic                  synth_band;
  logic [QWidth-1:0]     q;
  logic [ProdWidth-1:0]  prod;
  logic [IntWidth:0]     nint;
  logic [QWidth-1:0]     nfrac;

  assign low_band   = (info_i.band == BandC850) || (info_i.band == BandC900);
  assign synth_band = info_i.band[BandWidth-1] == 1'b0;

  // floor(vco / 4): freq for a x4 VCO, freq / 2 for a x2 VCO
  assign q     = low_band ? info_i.freq[QWidth-1:0] : info_i.freq[QWidth:1];
  assign prod  = ProdWidth'(q) * ProdWidth'(RecipMul);
  assign nint  = prod[RecipShift +: IntWidth+1];
  assign nfrac = q - QWidth'(FracDiv * QWidth'(nint));

  always_comb begin
    freq_tenths_mhz_o = '0;
    band_code_o       = '0;
    band_select_o     = '0;
    tx_path_o         = 1'b0;
    pll_integer_o     = '0;
    pll_fraction_o    = '0;
    out_of_spec_o     = 1'b0;
    status_o          = StatNoBand;
    if (info_i.in_band) begin
      freq_tenths_mhz_o = info_i.freq;
      band_code_o       = info_i.band;
      status_o          = StatUnsupported;
      if (synth_band) begin
        band_select_o  = info_i.band[SelWidth-1:0];
        tx_path_o      = info_i.uplink && low_band;
        pll_integer_o  = nint[IntWidth-1:0];
        pll_fraction_o = nfrac[FracWidth-1:0];
        out_of_spec_o  = nint[IntWidth];
        status_o       = StatOk;
      end
    end
  end

endmodule
